/* design/tcw_pkg.sv */
// ---------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command codes, cell constants and the controller/datapath interface.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_BS    = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_SHOW  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [7:0]  CHAR_NL    = 8'h0A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_BLANK = 8'h20;
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] CELL_RESET = 16'h0720;

  typedef enum logic [1:0] {
    LEN_ROW,
    LEN_COPY,
    LEN_TERM,
    LEN_ALL
  } len_sel_t;

  typedef struct packed {
    logic     load;
    logic     set_upd;
    logic     newline;
    logic     scroll_cur;
    logic     bs_step;
    logic     cur_zero;
    logic     show;
    logic     calc_addr;
    logic     rd_en;
    logic     rd_src;
    logic     set_rdv;
    logic     wr_char;
    logic     wr_copy;
    logic     wr_fill;
    logic     fill_init;
    logic     ptr_base;
    logic     ptr_zero;
    logic     cnt_clr;
    len_sel_t len;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       term_ok;
    logic       term_shown;
    logic       is_nl;
    logic       row_pend;
    logic       row_last;
    logic       at_origin;
    logic       rd_ok;
    logic       cnt_last;
  } dp_status_t;

  typedef struct packed {
    logic        upd;
    logic [10:0] pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } result_t;

endpackage

/* design/tcw_dp.sv */
// ---------------------------------------------------------------------------
// tcw_dp: text console datapath
// Holds the cell memory, the cursors, the shown terminal and the attribute,
// and carries out the steps that the controller commands.
// ---------------------------------------------------------------------------
module tcw_dp #(
  parameter int COLS      = 80,
  parameter int ROWS      = 25,
  parameter int TERMINALS = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcw_pkg::dp_cmd_t       cmd,
  output tcw_pkg::dp_status_t    st,
  output tcw_pkg::result_t       res,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_attr,
  input  logic [2:0]             in_command,
  input  logic [1:0]             in_terminal,
  input  logic [7:0]             in_char,
  input  logic [4:0]             in_row,
  input  logic [6:0]             in_col
);
  import tcw_pkg::*;

  localparam int CPT   = ROWS * COLS;
  localparam int TOTAL = TERMINALS * CPT;
  localparam int AW    = $clog2(TOTAL);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  localparam logic [AW-1:0] LIM_ROW  = AW'(COLS - 1);
  localparam logic [AW-1:0] LIM_COPY = AW'((ROWS - 1) * COLS - 1);
  localparam logic [AW-1:0] LIM_TERM = AW'(CPT - 1);
  localparam logic [AW-1:0] LIM_ALL  = AW'(TOTAL - 1);

  logic [15:0]   mem [TOTAL];
  logic [15:0]   rdata_r;

  logic [RW-1:0] crow_r [TERMINALS];
  logic [CW-1:0] ccol_r [TERMINALS];
  logic [TW-1:0] shown_r;
  logic [7:0]    attr_r;

  logic [2:0]    cmd_r;
  logic [1:0]    term_r;
  logic [7:0]    char_r;
  logic [4:0]    row_r;
  logic [6:0]    col_r;
  logic [TW-1:0] tgt_r;
  logic          tgt_ok_r;
  logic          term_ok_r;
  logic [RW-1:0] wrow_r;
  logic [CW-1:0] wcol_r;
  logic [AW-1:0] tbase_r;
  logic [AW-1:0] ptr_r;
  logic [AW-1:0] cnt_r;
  len_sel_t      len_r;
  logic          upd_r;
  logic          rdv_r;

  logic          use_shown;
  logic [TW-1:0] tgt_sel;
  logic          tgt_ok_sel;
  logic [AW-1:0] addr_nxt;
  logic [AW-1:0] raddr;
  logic [AW-1:0] lim;
  logic          we;
  logic [15:0]   wdata;

  assign use_shown  = (in_command == CMD_BS) || (in_command == CMD_CLEAR);
  assign tgt_sel    = use_shown ? shown_r : TW'(in_terminal);
  assign tgt_ok_sel = use_shown || (in_terminal < TERMINALS);

  always_comb begin
    if (cmd_r == CMD_READ) begin
      addr_nxt = tbase_r + AW'(row_r * COLS) + AW'(col_r);
    end else begin
      addr_nxt = tbase_r + AW'(wrow_r * COLS) + AW'(wcol_r);
    end
  end

  assign raddr = cmd.rd_src ? (ptr_r + AW'(COLS)) : ptr_r;
  assign we    = cmd.wr_char | cmd.wr_copy | cmd.wr_fill;

  always_comb begin
    if (cmd.wr_copy) begin
      wdata = rdata_r;
    end else if (cmd.wr_char) begin
      wdata = {attr_r, char_r};
    end else if (cmd.fill_init) begin
      wdata = CELL_RESET;
    end else begin
      wdata = {attr_r, CHAR_BLANK};
    end
  end

  always_comb begin
    case (len_r)
      LEN_ROW:  lim = LIM_ROW;
      LEN_COPY: lim = LIM_COPY;
      LEN_TERM: lim = LIM_TERM;
      LEN_ALL:  lim = LIM_ALL;
      default:  lim = LIM_ALL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ptr_r] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TERMINALS; i++) begin
        crow_r[i] <= '0;
        ccol_r[i] <= '0;
      end
      shown_r <= '0;
      attr_r  <= ATTR_RESET;
      upd_r   <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_attr;
      end
      if (cmd.load) begin
        upd_r <= 1'b0;
        rdv_r <= 1'b0;
      end else begin
        if (cmd.set_upd) begin
          upd_r <= 1'b1;
        end
        if (cmd.set_rdv) begin
          rdv_r <= 1'b1;
        end
      end
      if (cmd.show) begin
        shown_r <= tgt_r;
      end
      if (cmd.emit && tgt_ok_r) begin
        crow_r[tgt_r] <= wrow_r;
        ccol_r[tgt_r] <= wcol_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_command;
      term_r    <= in_terminal;
      char_r    <= in_char;
      row_r     <= in_row;
      col_r     <= in_col;
      tgt_r     <= tgt_sel;
      tgt_ok_r  <= tgt_ok_sel;
      term_ok_r <= (in_terminal < TERMINALS);
      tbase_r   <= AW'(tgt_sel * CPT);
      wrow_r    <= tgt_ok_sel ? crow_r[tgt_sel] : '0;
      wcol_r    <= tgt_ok_sel ? ccol_r[tgt_sel] : '0;
    end else if (cmd.newline) begin
      wrow_r <= wrow_r + RW'(1);
      wcol_r <= '0;
    end else if (cmd.scroll_cur) begin
      wrow_r <= RW'(ROWS - 1);
      wcol_r <= '0;
    end else if (cmd.bs_step) begin
      if (wcol_r == '0) begin
        wcol_r <= CW'(COLS - 1);
        wrow_r <= wrow_r - RW'(1);
      end else begin
        wcol_r <= wcol_r - CW'(1);
      end
    end else if (cmd.cur_zero) begin
      wrow_r <= '0;
      wcol_r <= '0;
    end else if (cmd.wr_char) begin
      if (wcol_r == CW'(COLS - 1)) begin
        wcol_r <= '0;
        wrow_r <= wrow_r + RW'(1);
      end else begin
        wcol_r <= wcol_r + CW'(1);
      end
    end

    if (cmd.ptr_zero) begin
      ptr_r <= '0;
    end else if (cmd.ptr_base) begin
      ptr_r <= tbase_r;
    end else if (cmd.calc_addr) begin
      ptr_r <= addr_nxt;
    end else if (cmd.wr_copy || cmd.wr_fill) begin
      ptr_r <= ptr_r + AW'(1);
    end

    if (cmd.cnt_clr) begin
      cnt_r <= '0;
      len_r <= cmd.len;
    end else if (cmd.wr_copy || cmd.wr_fill) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  assign st.cmd        = cmd_r;
  assign st.term_ok    = term_ok_r;
  assign st.term_shown = (3'(term_r) == 3'(shown_r));
  assign st.is_nl      = (char_r == CHAR_NL) || (char_r == CHAR_CR);
  assign st.row_pend   = (wrow_r >= RW'(ROWS));
  assign st.row_last   = (wrow_r >= RW'(ROWS - 1));
  assign st.at_origin  = (wrow_r == '0) && (wcol_r == '0);
  assign st.rd_ok      = term_ok_r && (row_r < ROWS) && (col_r < COLS);
  assign st.cnt_last   = (cnt_r == lim);

  assign res.upd       = upd_r;
  assign res.pos       = upd_r ? 11'(wrow_r * COLS + wcol_r) : 11'd0;
  assign res.cell_char = rdv_r ? rdata_r[7:0] : 8'd0;
  assign res.cell_attr = rdv_r ? rdata_r[15:8] : 8'd0;

endmodule

/* design/tcw_ctrl.sv */
// ---------------------------------------------------------------------------
// tcw_ctrl: text console controller
// Sequences the clearing pass after reset, command decode, scrolls, clears,
// cell writes and reads, and hands each result to the output register.
// ---------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  tcw_pkg::dp_status_t st,
  output tcw_pkg::dp_cmd_t    cmd
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    S_INIT_START,
    S_INIT_FILL,
    S_IDLE,
    S_DECODE,
    S_ADDR,
    S_ACT,
    S_SC_START,
    S_SC_RD,
    S_SC_WR,
    S_SC_BLANK,
    S_FILL,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT_START: begin
        cmd.ptr_zero = 1'b1;
        cmd.cnt_clr  = 1'b1;
        cmd.len      = LEN_ALL;
        state_nxt    = S_INIT_FILL;
      end
      S_INIT_FILL: begin
        cmd.wr_fill   = 1'b1;
        cmd.fill_init = 1'b1;
        if (st.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EMIT;
        case (st.cmd)
          CMD_PUT: begin
            if (st.term_ok) begin
              cmd.set_upd = st.term_shown;
              if (st.is_nl) begin
                if (st.row_last) begin
                  state_nxt = S_SC_START;
                end else begin
                  cmd.newline = 1'b1;
                end
              end else if (st.row_pend) begin
                state_nxt = S_SC_START;
              end else begin
                state_nxt = S_ADDR;
              end
            end
          end
          CMD_BS: begin
            if (!st.at_origin) begin
              cmd.bs_step = 1'b1;
              cmd.set_upd = 1'b1;
              state_nxt   = S_ADDR;
            end
          end
          CMD_CLEAR: begin
            cmd.cur_zero = 1'b1;
            cmd.set_upd  = 1'b1;
            cmd.ptr_base = 1'b1;
            cmd.cnt_clr  = 1'b1;
            cmd.len      = LEN_TERM;
            state_nxt    = S_FILL;
          end
          CMD_SHOW: begin
            if (st.term_ok) begin
              cmd.show    = 1'b1;
              cmd.set_upd = 1'b1;
            end
          end
          CMD_READ: begin
            if (st.rd_ok) begin
              state_nxt = S_ADDR;
            end
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = S_ACT;
      end
      S_ACT: begin
        case (st.cmd)
          CMD_PUT:  cmd.wr_char = 1'b1;
          CMD_BS:   cmd.wr_fill = 1'b1;
          CMD_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.set_rdv = 1'b1;
          end
          default:  cmd.rd_en = 1'b0;
        endcase
        state_nxt = S_EMIT;
      end
      S_SC_START: begin
        cmd.ptr_base = 1'b1;
        cmd.cnt_clr  = 1'b1;
        cmd.len      = LEN_COPY;
        state_nxt    = S_SC_RD;
      end
      S_SC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = 1'b1;
        state_nxt  = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.wr_copy = 1'b1;
        if (st.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          cmd.len     = LEN_ROW;
          state_nxt   = S_SC_BLANK;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_SC_BLANK: begin
        cmd.wr_fill = 1'b1;
        if (st.cnt_last) begin
          cmd.scroll_cur = 1'b1;
          state_nxt      = st.is_nl ? S_EMIT : S_ADDR;
        end
      end
      S_FILL: begin
        cmd.wr_fill = 1'b1;
        if (st.cnt_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT_START;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/text_console_writer.sv */
// ---------------------------------------------------------------------------
// text_console_writer: multi-terminal text-mode console
// Keeps TERMINALS grids of ROWS x COLS character/attribute cells with one
// cursor each, and answers every command beat with exactly one result beat.
//
// Input beats carry a command in in_tuser and its operands in in_tdata.
// Each result beat carries the cursor flag in out_tuser and the cursor
// position and read cell in out_tdata. cfg_* writes the attribute byte; it
// is always ready and must only be written while the console is idle.
// After reset a clearing pass writes all cells, during which in_tready
// stays low. One command at a time is handled: show terminal, unknown
// commands, a newline without a scroll and a put, backspace or read that
// does nothing go from decode straight to the emit state; a printed
// character, a backspace and a cell read first pass through the address
// and action states. The controller returns to idle after each result.
// A scroll copies every cell up one row, each move a memory read followed
// by a write, and then blanks the last row; a clear writes every cell of
// the shown terminal.
// The result sits in an output register: a new command is taken while it
// waits, but the next result holds in the controller until out_tready.
// ---------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLS      = 80,
  parameter int ROWS      = 25,
  parameter int TERMINALS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // terminal, char_code, row, col
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_pos, cell_char, cell_attr
  output logic [0:0]  out_tuser,  // cursor_update
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tcw_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;
  result_t    dp_res;

  logic        out_valid_r;
  logic        out_upd_r;
  logic [10:0] out_pos_r;
  logic [7:0]  out_char_r;
  logic [7:0]  out_attr_r;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .st       (dp_st),
    .cmd      (dp_cmd)
  );

  tcw_dp #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .TERMINALS (TERMINALS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .st          (dp_st),
    .res         (dp_res),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_attr    (cfg_data),
    .in_command  (in_tuser),
    .in_terminal (in_tdata[1:0]),
    .in_char     (in_tdata[9:2]),
    .in_row      (in_tdata[14:10]),
    .in_col      (in_tdata[21:15])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      out_upd_r  <= dp_res.upd;
      out_pos_r  <= dp_res.pos;
      out_char_r <= dp_res.cell_char;
      out_attr_r <= dp_res.cell_attr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_upd_r;
  assign out_tdata  = {5'd0, out_attr_r, out_char_r, out_pos_r};

  a_reset_blocks_input : assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command accepted while one is in progress");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before it was taken");

  a_read_no_cursor : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[26:11] == 16'd0)
    else $error("cursor update beat carries cell data");

endmodule

/* tb/console_checker.sv */
// ---------------------------------------------------------------------------
// console_checker: result predictor and scoreboard of the text console writer
// Watches the command, result and attribute channels. Every accepted command
// beat runs through a local model of the terminals, cursors and shown
// terminal. The result it should give is queued, and each result beat is
// compared field by field with the oldest queued result.
// ---------------------------------------------------------------------------
module console_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          outstanding,
  output int          failures,
  output int          checked,
  output int          scrolls
);

  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int TERMS      = 3;
  localparam int TERM_CELLS = ROWS * COLS;

  logic [15:0] screen [TERMS * TERM_CELLS];
  int unsigned cur_row [TERMS];
  int unsigned cur_col [TERMS];
  int unsigned shown_term;
  logic [7:0]  text_attr;
  result_t     expected_results [$];
  int          fail_count;
  int          checked_count;
  int          scroll_count;

  assign failures = fail_count;
  assign checked  = checked_count;
  assign scrolls  = scroll_count;

  function automatic void scroll_terminal(int unsigned t);
    int unsigned base;
    base = t * TERM_CELLS;
    for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
      screen[base + i] = screen[base + i + COLS];
    end
    for (int c = 0; c < COLS; c++) begin
      screen[base + (ROWS - 1) * COLS + c] = {text_attr, CHAR_BLANK};
    end
    cur_row[t] = ROWS - 1;
    cur_col[t] = 0;
    scroll_count++;
  endfunction

  function automatic result_t console_step(logic [2:0] cmd, logic [1:0] term,
                                           logic [7:0] ch, logic [4:0] row,
                                           logic [6:0] col);
    result_t     res;
    int unsigned t;
    int unsigned s;
    logic        upd;
    logic [15:0] cell_word;
    res = '0;
    upd = 1'b0;
    t = term;
    s = shown_term;
    case (cmd)
      CMD_PUT: begin
        if (t < TERMS) begin
          if (ch == CHAR_NL || ch == CHAR_CR) begin
            cur_row[t]++;
            cur_col[t] = 0;
            if (cur_row[t] >= ROWS) scroll_terminal(t);
          end else begin
            if (cur_row[t] >= ROWS) scroll_terminal(t);
            screen[t * TERM_CELLS + cur_row[t] * COLS + cur_col[t]] = {text_attr, ch};
            cur_col[t]++;
            if (cur_col[t] >= COLS) begin
              cur_col[t] = 0;
              cur_row[t]++;
            end
          end
          upd = (t == s);
        end
      end
      CMD_BS: begin
        if (cur_row[s] != 0 || cur_col[s] != 0) begin
          if (cur_col[s] == 0) begin
            cur_col[s] = COLS - 1;
            cur_row[s]--;
          end else begin
            cur_col[s]--;
          end
          screen[s * TERM_CELLS + cur_row[s] * COLS + cur_col[s]] = {text_attr, CHAR_BLANK};
          upd = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < TERM_CELLS; i++) begin
          screen[s * TERM_CELLS + i] = {text_attr, CHAR_BLANK};
        end
        cur_row[s] = 0;
        cur_col[s] = 0;
        upd = 1'b1;
      end
      CMD_SHOW: begin
        if (t < TERMS) begin
          shown_term = t;
          upd = 1'b1;
        end
      end
      CMD_READ: begin
        if (t < TERMS && row < ROWS && col < COLS) begin
          cell_word = screen[t * TERM_CELLS + row * COLS + col];
          res.cell_char = cell_word[7:0];
          res.cell_attr = cell_word[15:8];
        end
      end
      default: begin
      end
    endcase
    if (upd) begin
      res.upd = 1'b1;
      res.pos = 11'(cur_row[shown_term] * COLS + cur_col[shown_term]);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TERMS * TERM_CELLS; i++) screen[i] = CELL_RESET;
      for (int t = 0; t < TERMS; t++) begin
        cur_row[t] = 0;
        cur_col[t] = 0;
      end
      shown_term = 0;
      text_attr = ATTR_RESET;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command waiting: tuser %0h tdata %0h",
                 out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (out_tuser[0] !== want.upd) begin
            $error("cursor_update mismatch: expected %0d, actual %0d", want.upd, out_tuser[0]);
            fail_count++;
          end
          if (out_tdata[10:0] !== want.pos) begin
            $error("cursor_pos mismatch: expected %0d, actual %0d", want.pos, out_tdata[10:0]);
            fail_count++;
          end
          if (out_tdata[18:11] !== want.cell_char) begin
            $error("cell_char mismatch: expected %0h, actual %0h",
                   want.cell_char, out_tdata[18:11]);
            fail_count++;
          end
          if (out_tdata[26:19] !== want.cell_attr) begin
            $error("cell_attr mismatch: expected %0h, actual %0h",
                   want.cell_attr, out_tdata[26:19]);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) text_attr = cfg_data;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(console_step(in_tuser, in_tdata[1:0], in_tdata[9:2],
                                                in_tdata[14:10], in_tdata[21:15]));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

/* tb/text_console_writer_tb.sv */
// ---------------------------------------------------------------------------
// text_console_writer_tb: stimulus and verdict for the text console writer
// Drives a short directed command list and then random streams of text
// lines, newline bursts, backspaces, clears, terminal switches and cell
// reads, under several attribute settings and random idling on both sides.
// All checking is done by the console_checker instance.
// ---------------------------------------------------------------------------
module text_console_writer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int LIMIT_CYCLES = 10_000_000;
  localparam int CHUNK_BEATS  = 130;
  localparam int SETTLE       = 32;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int outstanding;
  int failures;
  int checked;
  int scrolls;
  int cycle_count = 0;
  int beats_sent = 0;
  int attr_writes = 0;
  bit calm = 1'b1;

  always #5 clk = ~clk;

  text_console_writer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  console_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .failures    (failures),
    .checked     (checked),
    .scrolls     (scrolls)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[text_console_writer] ERROR");
      $finish;
    end
  end

  task automatic send_command(logic [2:0] cmd, logic [1:0] term, logic [7:0] ch,
                              logic [4:0] row, logic [6:0] col);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      in_tuser  <= 3'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, col, row, ch, term};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    attr_writes++;
  endtask

  task automatic put_text_line(logic [1:0] term);
    int len;
    logic [7:0] ch;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
    for (int i = 0; i < len; i++) begin
      ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(8'h21, 8'h7E));
      send_command(CMD_PUT, term, ch, 5'($urandom), 7'($urandom));
    end
    send_command(CMD_PUT, term, $urandom_range(0, 1) ? CHAR_NL : CHAR_CR,
                 5'($urandom), 7'($urandom));
  endtask

  task automatic random_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    calm = ($urandom_range(0, 5) == 0);
    if (pick < 50) begin
      put_text_line(2'($urandom_range(0, 2)));
    end else if (pick < 58) begin
      n = $urandom_range(8, 30);
      for (int i = 0; i < n; i++) begin
        send_command(CMD_PUT, 2'($urandom_range(0, 2)) & 2'($urandom_range(2, 3)) ,
                     $urandom_range(0, 1) ? CHAR_NL : CHAR_CR, 5'($urandom), 7'($urandom));
      end
    end else if (pick < 68) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        send_command(CMD_BS, 2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
      end
    end else if (pick < 73) begin
      send_command(CMD_CLEAR, 2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    end else if (pick < 81) begin
      send_command(CMD_SHOW, 2'($urandom_range(0, 3)), 8'($urandom), 5'($urandom),
                   7'($urandom));
    end else if (pick < 93) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_command(CMD_READ, 2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
        end else begin
          send_command(CMD_READ, 2'($urandom_range(0, 2)), 8'($urandom),
                       5'($urandom_range(0, 24)), 7'($urandom_range(0, 79)));
        end
      end
    end else begin
      send_command(3'($urandom), 2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int stall;
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [7:0] attr_values [5];
    int target;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_command(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd0);
    send_command(CMD_READ, 2'd2, 8'hFF, 5'd24, 7'd79);
    send_command(CMD_PUT, 2'd0, 8'h41, 5'd0, 7'd0);
    send_command(CMD_PUT, 2'd0, 8'hFF, 5'd0, 7'd0);
    send_command(CMD_PUT, 2'd0, 8'h00, 5'd0, 7'd0);
    send_command(CMD_BS, 2'd0, 8'h00, 5'd0, 7'd0);
    send_command(CMD_PUT, 2'd0, CHAR_NL, 5'd0, 7'd0);
    send_command(CMD_BS, 2'd0, 8'h00, 5'd0, 7'd0);
    send_command(CMD_PUT, 2'd0, CHAR_CR, 5'd0, 7'd0);
    send_command(CMD_PUT, 2'd1, 8'h78, 5'd0, 7'd0);
    send_command(CMD_SHOW, 2'd3, 8'h00, 5'd0, 7'd0);
    send_command(CMD_PUT, 2'd3, 8'h7A, 5'd0, 7'd0);
    send_command(CMD_READ, 2'd3, 8'h00, 5'd0, 7'd0);
    send_command(CMD_READ, 2'd0, 8'h00, 5'd25, 7'd0);
    send_command(CMD_READ, 2'd0, 8'h00, 5'd31, 7'd127);
    send_command(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd0);
    send_command(CMD_SHOW, 2'd1, 8'h00, 5'd0, 7'd0);
    send_command(CMD_BS, 2'd1, 8'h00, 5'd0, 7'd0);
    send_command(CMD_PUT, 2'd1, 8'h79, 5'd0, 7'd0);
    send_command(CMD_BS, 2'd1, 8'h00, 5'd0, 7'd0);
    send_command(CMD_CLEAR, 2'd1, 8'h00, 5'd0, 7'd0);
    for (int c = CMD_READ + 1; c < 8; c++) begin
      send_command(3'(c), 2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    end
    send_command(CMD_SHOW, 2'd0, 8'h00, 5'd0, 7'd0);

    attr_values[0] = 8'hFF;
    attr_values[1] = 8'h00;
    attr_values[2] = 8'($urandom);
    attr_values[3] = 8'($urandom);
    attr_values[4] = 8'h5A;
    for (int k = 0; k < 5; k++) begin
      write_attribute(attr_values[k]);
      target = beats_sent + CHUNK_BEATS;
      while (beats_sent < target) random_sequence();
    end

    drain_results();
    $display("Sent %0d command beats under %0d attribute writes; %0d results checked.",
             beats_sent, attr_writes, checked);
    $display("The run took %0d cycles and went through %0d scrolls.", cycle_count, scrolls);
    if (failures == 0 && outstanding == 0) begin
      $display("[text_console_writer] OK");
    end else begin
      $display("[text_console_writer] ERROR");
    end
    $finish;
  end

endmodule
